>>> rtl/core/hashtp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hashtp_pkg
// Shared types and constants for the hash table probe lookup core.
// ----------------------------------------------------------------------------
package hashtp_pkg;

   localparam int KEY_W     = 32;
   localparam int VAL_W     = 32;
   localparam int SIDX_W    = 10;
   localparam int CSR_W     = 11;
   localparam int STAT_W    = 3;
   localparam int CNT_W     = 11;
   localparam int DVD_W     = 33;   // key, or slot index plus probe step
   localparam int DIV_CNT_W = 6;

   localparam int SLOT_COUNT_DEF = 1024;

   localparam logic [CSR_W-1:0] TABLE_SIZE_RST = 11'd1024;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   localparam logic [STAT_W-1:0] ST_FOUND      = 3'd0;
   localparam logic [STAT_W-1:0] ST_ZERO_INPUT = 3'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY      = 3'd2;
   localparam logic [STAT_W-1:0] ST_LIMIT      = 3'd3;
   localparam logic [STAT_W-1:0] ST_ZERO_VALUE = 3'd4;

   typedef struct packed {
      logic              operation;
      logic [SIDX_W-1:0] slot_index;
      logic [KEY_W-1:0]  key;
      logic [VAL_W-1:0]  value;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [VAL_W-1:0]  found_value;
      logic [CNT_W-1:0]  probe_count;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic clr;           // clearing pass: zero one slot
      logic wr;            // write beat accepted
      logic load;          // lookup beat accepted
      logic div_key;       // start key mod size
      logic idx_from_div;  // take remainder as slot index
      logic step;          // advance probe sequence
      logic finish;        // load result register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clr_last;
      logic req_lookup;
      logic zero_in;
      logic div_busy;
      logic step_small;
      logic done;
      logic out_free;
   } sts_type;

endpackage
`default_nettype wire

>>> rtl/core/hash_table_probe_lookup_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hash_table_probe_lookup_core
// Open-addressed key/value table with probing lookup.
// ----------------------------------------------------------------------------
// After reset the core sweeps both slot memories to zero, one slot per cycle,
// and req_stall stays high until the sweep is done; csr writes are taken
// during the sweep. A lookup first reduces the key mod size and then reads
// and checks one slot per probe. The wide steps (the first key mod size and
// the early large probe steps, which shrink as the step roughly halves each
// time) go through a one-bit-per-cycle remainder unit of 33 iterations; a
// probe step below the table size wraps with a single subtract. Each probe
// costs one registered read of the key and value memories. One lookup is
// in flight at a time; the result register lets a new beat be taken while
// the last result waits on rsp_stall.
// ----------------------------------------------------------------------------
module hash_table_probe_lookup_core
   import hashtp_pkg::*;
#(
   parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire req_type          req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rsp_type               rsp_data,
   input  wire logic             csr_wr_en,
   input  wire logic [CSR_W-1:0] csr_wr_data
);

   cmd_type cmd;
   sts_type sts;

   hashtp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   hashtp_dp #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule
`default_nettype wire

>>> rtl/core/hashtp_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hashtp_div
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module hashtp_div
   import hashtp_pkg::*;
#(
   parameter int IDX_W = 10,
   parameter int SZ_W  = 11
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DVD_W-1:0] dividend,
   input  wire logic [SZ_W-1:0]  divisor,
   output logic                  busy,
   output logic [IDX_W-1:0]      rem
);

   localparam logic [DIV_CNT_W-1:0] ITER = DIV_CNT_W'(DVD_W);

   logic [DVD_W-1:0]     dvd_ff, dvd_in;
   logic [IDX_W-1:0]     rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W:0]       shifted;
   logic [IDX_W:0]       diff;
   logic                 ge;

   always_comb begin
      shifted = {rem_ff, dvd_ff[DVD_W-1]};
      ge      = shifted >= (IDX_W+1)'(divisor);
      diff    = shifted - (IDX_W+1)'(divisor);
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         dvd_in = dividend;
         rem_in = '0;
         cnt_in = ITER;
      end else if (cnt_ff != '0) begin
         dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
         // partial remainder stays below divisor, so it fits the index width
         rem_in = ge ? diff[IDX_W-1:0] : shifted[IDX_W-1:0];
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   assign busy = cnt_ff != '0;
   assign rem  = rem_ff;

endmodule
`default_nettype wire

>>> rtl/core/hashtp_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hashtp_dp
// Datapath: slot memories, probe registers, remainder unit, result register.
// ----------------------------------------------------------------------------
module hashtp_dp
   import hashtp_pkg::*;
#(
   parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cmd_type          cmd,
   output sts_type               sts,
   input  wire req_type          req_data,
   input  wire logic             csr_wr_en,
   input  wire logic [CSR_W-1:0] csr_wr_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rsp_type               rsp_data
);

   localparam int IDX_W = $clog2(SLOT_COUNT);
   localparam int SZ_W  = $clog2(SLOT_COUNT + 1);
   localparam int CMP_W = (SZ_W > CNT_W) ? SZ_W : CNT_W;

   logic [KEY_W-1:0] key_mem [SLOT_COUNT];
   logic [VAL_W-1:0] val_mem [SLOT_COUNT];

   logic [CSR_W-1:0] table_size_ff, table_size_in;
   logic [IDX_W-1:0] clr_idx_ff, clr_idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [SZ_W-1:0]  size_ff, size_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [KEY_W-1:0] probe_ff, probe_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [KEY_W-1:0] rd_key_ff;
   logic [VAL_W-1:0] rd_val_ff;
   rsp_type          rsp_ff, rsp_in;

   logic [SZ_W-1:0]  size_clamp;
   logic             wr_in_range;
   logic             mem_we;
   logic [IDX_W-1:0] mem_addr;
   logic [KEY_W-1:0] mem_key;
   logic [VAL_W-1:0] mem_val;
   logic [KEY_W-1:0] probe_nxt;
   logic [DVD_W-1:0] sum;
   logic [DVD_W-1:0] sum_wrap;
   logic             step_small;
   logic             hit;
   logic             empty;
   logic             limit;
   logic             zero_in;
   logic             div_start;
   logic [DVD_W-1:0] div_dvd;
   logic             div_busy;
   logic [IDX_W-1:0] div_rem;
   rsp_type          result;

   hashtp_div #(
      .IDX_W (IDX_W),
      .SZ_W  (SZ_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (size_ff),
      .busy     (div_busy),
      .rem      (div_rem)
   );

   always_comb begin
      size_clamp  = (32'(table_size_ff) > 32'(SLOT_COUNT)) ?
                    SZ_W'(SLOT_COUNT) : SZ_W'(table_size_ff);
      wr_in_range = 32'(req_data.slot_index) < 32'(SLOT_COUNT);

      mem_we   = cmd.clr | (cmd.wr & wr_in_range);
      mem_addr = cmd.clr ? clr_idx_ff : IDX_W'(req_data.slot_index);
      mem_key  = cmd.clr ? '0 : req_data.key;
      mem_val  = cmd.clr ? '0 : req_data.value;

      probe_nxt  = (probe_ff >> 1) + KEY_W'(1);
      sum        = DVD_W'(idx_ff) + DVD_W'(probe_nxt);
      // small step: idx + probe < 2*size, one subtract wraps it
      step_small = probe_nxt < KEY_W'(size_ff);
      sum_wrap   = (sum >= DVD_W'(size_ff)) ? sum - DVD_W'(size_ff) : sum;

      zero_in = (key_ff == '0) || (size_ff == '0);
      hit     = rd_key_ff == key_ff;
      empty   = rd_key_ff == '0;
      limit   = CMP_W'(count_ff) >= CMP_W'(size_ff);

      div_start = cmd.div_key | (cmd.step & ~step_small);
      div_dvd   = cmd.div_key ? DVD_W'(key_ff) : sum;

      result.probe_count = count_ff;
      result.found_value = '0;
      if (zero_in) begin
         result.status      = ST_ZERO_INPUT;
         result.probe_count = '0;
      end else if (hit) begin
         if (rd_val_ff == '0) begin
            result.status = ST_ZERO_VALUE;
         end else begin
            result.status      = ST_FOUND;
            result.found_value = rd_val_ff;
         end
      end else if (empty) begin
         result.status = ST_EMPTY;
      end else begin
         result.status = ST_LIMIT;
      end

      table_size_in = csr_wr_en ? csr_wr_data : table_size_ff;
      clr_idx_in    = cmd.clr ? clr_idx_ff + 1'b1 : clr_idx_ff;

      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      size_in  = size_ff;
      key_in   = key_ff;
      probe_in = probe_ff;
      idx_in   = idx_ff;
      count_in = count_ff;
      if (cmd.load) begin
         size_in  = size_clamp;
         key_in   = req_data.key;
         probe_in = req_data.key;
         count_in = CNT_W'(1);
      end
      if (cmd.idx_from_div) begin
         idx_in = div_rem;
      end
      if (cmd.step) begin
         probe_in = probe_nxt;
         count_in = count_ff + 1'b1;
         if (step_small) begin
            idx_in = sum_wrap[IDX_W-1:0];
         end
      end

      sts.clr_last   = clr_idx_ff == IDX_W'(SLOT_COUNT - 1);
      sts.req_lookup = req_data.operation == OP_LOOKUP;
      sts.zero_in    = zero_in;
      sts.div_busy   = div_busy;
      sts.step_small = step_small;
      sts.done       = hit | empty | limit;
      sts.out_free   = ~rsp_valid_ff | ~rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= TABLE_SIZE_RST;
         clr_idx_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         table_size_ff <= table_size_in;
         clr_idx_ff    <= clr_idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      size_ff  <= size_in;
      key_ff   <= key_in;
      probe_ff <= probe_in;
      idx_ff   <= idx_in;
      count_ff <= count_in;
      rsp_ff   <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem[mem_addr] <= mem_key;
         val_mem[mem_addr] <= mem_val;
      end
      rd_key_ff <= key_mem[idx_ff];
      rd_val_ff <= val_mem[idx_ff];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

>>> rtl/core/hashtp_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hashtp_ctrl
// Controller: clearing pass, beat acceptance and probe walk sequencing.
// ----------------------------------------------------------------------------
module hashtp_ctrl
   import hashtp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_START = 6'b000100,
      S_DIV   = 6'b001000,
      S_READ  = 6'b010000,
      S_CHECK = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr = 1'b1;
            if (sts.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               if (sts.req_lookup) begin
                  cmd.load = 1'b1;
                  state_in = S_START;
               end else begin
                  cmd.wr = 1'b1;
               end
            end
         end
         S_START: begin
            if (sts.zero_in) begin
               if (sts.out_free) begin
                  cmd.finish = 1'b1;
                  state_in   = S_IDLE;
               end
            end else begin
               cmd.div_key = 1'b1;
               state_in    = S_DIV;
            end
         end
         S_DIV: begin
            if (!sts.div_busy) begin
               cmd.idx_from_div = 1'b1;
               state_in         = S_READ;
            end
         end
         S_READ: begin
            state_in = S_CHECK;   // slot data lands in the read register
         end
         S_CHECK: begin
            if (sts.done) begin
               if (sts.out_free) begin
                  cmd.finish = 1'b1;
                  state_in   = S_IDLE;
               end
            end else begin
               cmd.step = 1'b1;
               state_in = sts.step_small ? S_READ : S_DIV;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;

endmodule
`default_nettype wire

>>> dv/tb_hash_table_probe_lookup_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hash_table_probe_lookup_core
// Self-checking bench for the open-addressed probe lookup core. A short
// directed pass hits the empty, found, zero-value, zero-key, zero-size,
// oversize and probe-limit cases; random phases then change the table size
// and mix chained inserts, lookups of stored keys and noise writes. Results
// are compared field by field against a mirror of the slot tables.
// ----------------------------------------------------------------------------
module tb_hash_table_probe_lookup_core;
   import hashtp_pkg::*;

   localparam int SLOTS = SLOT_COUNT_DEF;

   // mirror of the slot tables plus the queue of pending lookup results
   class probe_lookup_tracker;
      logic [KEY_W-1:0] slot_keys [SLOTS];
      logic [VAL_W-1:0] slot_vals [SLOTS];
      logic [CSR_W-1:0] table_size;
      rsp_type          expected_q [$];
      int unsigned      mismatches;

      function new();
         foreach (slot_keys[i]) begin
            slot_keys[i] = '0;
            slot_vals[i] = '0;
         end
         table_size = TABLE_SIZE_RST;
         mismatches = 0;
      endfunction

      function int unsigned span();
         return (table_size > SLOTS) ? SLOTS : table_size;
      endfunction

      // follow the probe chain until the key, an empty slot or the size limit
      function void walk(input logic [KEY_W-1:0] key, output int unsigned slot,
                         output int unsigned visited);
         int unsigned      n;
         logic [KEY_W-1:0] step;
         longint unsigned  pos;
         n       = span();
         pos     = key % n;
         step    = key;
         visited = 1;
         while (slot_keys[pos] != 0 && slot_keys[pos] != key && visited < n) begin
            step = (step >> 1) + 32'd1;
            pos  = (pos + step) % n;
            visited++;
         end
         slot = int'(pos);
      endfunction

      // slot where an insert of this key ends up, -1 if the chain is full
      function int landing_slot(input logic [KEY_W-1:0] key);
         int unsigned slot;
         int unsigned visited;
         if (key == 0 || span() == 0) return -1;
         walk(key, slot, visited);
         if (slot_keys[slot] == 0 || slot_keys[slot] == key) return int'(slot);
         return -1;
      endfunction

      function rsp_type predict_lookup(input logic [KEY_W-1:0] key);
         rsp_type     r;
         int unsigned slot;
         int unsigned visited;
         r = '0;
         if (key == 0 || span() == 0) begin
            r.status = ST_ZERO_INPUT;
            return r;
         end
         walk(key, slot, visited);
         r.probe_count = CNT_W'(visited);
         if (slot_keys[slot] == key) begin
            if (slot_vals[slot] == 0) begin
               r.status = ST_ZERO_VALUE;
            end else begin
               r.status      = ST_FOUND;
               r.found_value = slot_vals[slot];
            end
         end else if (slot_keys[slot] == 0) begin
            r.status = ST_EMPTY;
         end else begin
            r.status = ST_LIMIT;
         end
         return r;
      endfunction

      function void note_request(input req_type item);
         if (item.operation == OP_WRITE) begin
            if (item.slot_index < SLOTS) begin
               slot_keys[item.slot_index] = item.key;
               slot_vals[item.slot_index] = item.value;
            end
         end else begin
            expected_q = {expected_q, predict_lookup(item.key)};
         end
      endfunction

      function void flag(input string what, input logic [VAL_W-1:0] want,
                         input logic [VAL_W-1:0] got);
         mismatches++;
         $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      endfunction

      function void check_reply(input rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            flag("unexpected result (status)", '0, VAL_W'(got.status));
            return;
         end
         want = expected_q.pop_front();
         if (got.status !== want.status)
            flag("status", VAL_W'(want.status), VAL_W'(got.status));
         if (got.found_value !== want.found_value)
            flag("found_value", want.found_value, got.found_value);
         if (got.probe_count !== want.probe_count)
            flag("probe_count", VAL_W'(want.probe_count), VAL_W'(got.probe_count));
      endfunction

      function int unsigned outstanding();
         return expected_q.size();
      endfunction
   endclass

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_stall;
   req_type          req_data    = '0;
   logic             rsp_valid;
   logic             rsp_stall   = 1'b0;
   rsp_type          rsp_data;
   logic             csr_wr_en   = 1'b0;
   logic [CSR_W-1:0] csr_wr_data = '0;

   probe_lookup_tracker tracker = new();
   logic [KEY_W-1:0]    known_keys [$];
   int unsigned         burst_left    = 0;
   bit                  valid_dropped = 1'b1;
   int unsigned         stall_hold    = 0;

   hash_table_probe_lookup_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // receiver: stall runs, short ready runs and long quiet stretches
   always @(posedge clock) begin
      if (stall_hold != 0) begin
         stall_hold <= stall_hold - 1;
      end else if ($urandom_range(0, 2) == 0) begin
         rsp_stall  <= 1'b1;
         stall_hold <= $urandom_range(0, 20);
      end else begin
         rsp_stall  <= 1'b0;
         stall_hold <= ($urandom_range(0, 3) == 0) ? $urandom_range(100, 400)
                                                   : $urandom_range(0, 10);
      end
   end

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         tracker.check_reply(rsp_data);
   end

   initial begin
      #(64'd200_000_000);
      $display("*** FAILED ***");
      $finish;
   end

   task automatic send_item(input req_type item);
      int unsigned gap;
      req_data      <= item;
      req_valid     <= 1'b1;
      valid_dropped = 1'b0;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      tracker.note_request(item);
      if (burst_left != 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 30);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid     <= 1'b0;
            valid_dropped = 1'b1;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic store(input int unsigned slot, input logic [KEY_W-1:0] key,
                        input logic [VAL_W-1:0] val);
      req_type r;
      r.operation  = OP_WRITE;
      r.slot_index = SIDX_W'(slot);
      r.key        = key;
      r.value      = val;
      send_item(r);
   endtask

   // slot_index and value are don't-care on a lookup, so fill them with noise
   task automatic lookup(input logic [KEY_W-1:0] key);
      req_type r;
      r.operation  = OP_LOOKUP;
      r.slot_index = SIDX_W'($urandom());
      r.key        = key;
      r.value      = $urandom();
      send_item(r);
   endtask

   task automatic insert(input logic [KEY_W-1:0] key, input logic [VAL_W-1:0] val);
      int slot;
      slot = tracker.landing_slot(key);
      if (slot < 0) slot = $urandom_range(0, SLOTS - 1);
      store(slot, key, val);
   endtask

   // wait for every lookup result, then let a trailing write beat retire
   task automatic settle();
      if (!valid_dropped) begin
         req_valid     <= 1'b0;
         valid_dropped = 1'b1;
      end
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_size(input logic [CSR_W-1:0] size);
      csr_wr_data <= size;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      tracker.table_size = size;
   endtask

   task automatic run_mixed(input int unsigned count);
      int unsigned      pick;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] val;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            key = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4095) : $urandom();
            val = ($urandom_range(0, 9) == 0) ? '0 : $urandom();
            insert(key, val);
            known_keys = {known_keys, key};
            if (known_keys.size() > 64) void'(known_keys.pop_front());
         end else if (pick < 70 && known_keys.size() != 0) begin
            lookup(known_keys[$urandom_range(0, known_keys.size() - 1)]);
         end else if (pick < 85) begin
            key = ($urandom_range(0, 9) == 0) ? '0 : $urandom();
            lookup(key);
         end else begin
            key = ($urandom_range(0, 5) == 0) ? '0 : $urandom();
            val = ($urandom_range(0, 5) == 0) ? '0 : $urandom();
            store($urandom_range(0, SLOTS - 1), key, val);
         end
      end
   endtask

   initial begin
      logic [CSR_W-1:0] size_plan [0:11];
      size_plan = '{11'd16, 11'd2, 11'd1000, 11'd2047, 11'd1, 11'd64,
                    11'd0, 11'd1025, 11'd300, 11'd0, 11'd8, 11'd0};
      size_plan[9]  = $urandom_range(0, 2047);
      size_plan[11] = $urandom_range(0, 2047);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      write_size(11'd1024);

      // full-size table: miss, hit at the top slot, collision chain
      lookup(32'h0000_0000);
      lookup(32'hFFFF_FFFF);
      store(1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      lookup(32'hFFFF_FFFF);
      lookup(32'h0000_03FF);
      insert(32'h0000_03FF, 32'h1234_5678);
      lookup(32'h0000_03FF);
      store(0, 32'h0000_0400, 32'h0000_0000);
      lookup(32'h0000_0400);
      store(0, 32'h0000_0000, 32'h5555_AAAA);
      lookup(32'h0000_0400);
      insert(32'h5555_5555, 32'hAAAA_AAAA);
      lookup(32'h5555_5555);
      settle();

      // zero size: every lookup reports zero input
      write_size(11'd0);
      lookup(32'hFFFF_FFFF);
      settle();

      // size beyond the slot count clamps to it
      write_size(11'd2047);
      lookup(32'hFFFF_FFFF);
      settle();

      // small full table runs into the probe limit
      write_size(11'd4);
      store(0, 32'h10, 32'h100);
      store(1, 32'h11, 32'h101);
      store(2, 32'h12, 32'h102);
      store(3, 32'h13, 32'h103);
      lookup(32'h14);
      settle();

      write_size(11'd1);
      lookup(32'h7);
      lookup(32'h10);
      settle();

      foreach (size_plan[p]) begin
         write_size(size_plan[p]);
         run_mixed(84);
         settle();
      end

      if (tracker.mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

>>> hash_table_probe_lookup_core.f
rtl/core/hashtp_pkg.sv
rtl/core/hashtp_div.sv
rtl/core/hashtp_dp.sv
rtl/core/hashtp_ctrl.sv
rtl/core/hash_table_probe_lookup_core.sv
dv/tb_hash_table_probe_lookup_core.sv
